@@ hdl/lhos_pkg.sv @@
// Shared constants and beat payload types for the label histogram overlap score block.
// No dependencies.
`default_nettype none

package lhos_pkg;

    localparam int CNT_W     = 16;
    localparam int ACC_W     = 20;
    localparam int TOTAL_W   = 21;
    localparam int SCORE_W   = 16;
    localparam int SCALE_W   = 8;
    localparam int SCALE     = 200;

    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 8;

    typedef struct packed {
        logic [CNT_W-1:0]   count_first;
        logic [CNT_W-1:0]   count_second;
        logic               is_vertex_bin;
        logic [ACC_W-1:0]   prior_common;
        logic [TOTAL_W-1:0] total_size;
        logic               last;
    } lhos_in_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ACC_W-1:0]   common_total;
        logic               zero_total;
    } lhos_out_t;

endpackage

`default_nettype wire

@@ hdl/lhos_in_if.sv @@
// Valid/ready channel carrying one feature bin per beat.
// Depends on lhos_pkg.
`default_nettype none

interface lhos_in_if;
    import lhos_pkg::*;

    logic     valid;
    logic     ready;
    lhos_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/lhos_out_if.sv @@
// Valid/ready channel carrying one overlap score result per beat.
// Depends on lhos_pkg.
`default_nettype none

interface lhos_out_if;
    import lhos_pkg::*;

    logic      valid;
    logic      ready;
    lhos_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/label_histogram_overlap_score_top.sv @@
// Label histogram overlap score: sums min of bin counts over a run, then divides
// 200*common*2^FRACTION_BITS by total_size in a shared restoring-divide step unit.
// Depends on lhos_pkg, lhos_in_if, lhos_out_if.
// Throughput: a bin that is not last is taken every cycle while the block is in its accumulate state.
// After a last bin the divider produces one quotient bit per cycle; a zero total skips the
// divide and goes straight to the result beat; rst_n low (async) clears run state.
`default_nettype none

module label_histogram_overlap_score_top #(
    parameter int COUNT_BITS    = lhos_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = lhos_pkg::FRACTION_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    lhos_in_if.sink           bin,
    lhos_out_if.source        result
);
    import lhos_pkg::*;

    localparam int EFF_BITS = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
    localparam logic [CNT_W-1:0] CNT_MASK = {CNT_W{1'b1}} >> (CNT_W - EFF_BITS);
    localparam int PROD_W = ACC_W + SCALE_W;
    localparam int NUM_W  = PROD_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

    typedef enum logic [2:0] {
        ST_ACC  = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                skip_reg, skip_next;
    logic                start_reg, start_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;

    logic [NUM_W-1:0]    num_reg, num_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [SCORE_W-1:0]  quo_reg, quo_next;
    logic                ovf_reg, ovf_next;
    logic                zero_reg, zero_next;
    lhos_out_t           out_data_reg, out_data_next;

    logic                accept;
    logic                out_load;
    logic [CNT_W-1:0]    cnt_a, cnt_b, cnt_min, addend;
    logic [ACC_W-1:0]    acc_base, acc_new;
    logic                skip_now;
    logic [ACC_W:0]      acc_sum;
    logic [PROD_W-1:0]   prod;
    logic [TOTAL_W:0]    trial, diff;
    logic                qbit;
    logic [SCORE_W-1:0]  score_val;

    assign bin.ready    = (state_reg == ST_ACC);
    assign accept       = bin.valid && bin.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
    assign out_load     = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    // accumulate datapath
    always_comb
    begin
        cnt_a    = bin.data.count_first & CNT_MASK;
        cnt_b    = bin.data.count_second & CNT_MASK;
        cnt_min  = (cnt_a < cnt_b) ? cnt_a : cnt_b;
        acc_base = start_reg ? bin.data.prior_common : acc_reg;
        skip_now = start_reg ? (bin.data.prior_common != '0) : skip_reg;
        addend   = (bin.data.is_vertex_bin && skip_now) ? '0 : cnt_min;
        acc_sum  = {1'b0, acc_base} + {{(ACC_W + 1 - CNT_W){1'b0}}, addend};
        acc_new  = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        prod     = PROD_W'(acc_new) * PROD_W'(SCALE);
    end

    // shared divide step
    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        diff      = trial - {1'b0, total_reg};
        qbit      = !diff[TOTAL_W];
        score_val = zero_reg ? '0 : (ovf_reg ? {SCORE_W{1'b1}} : quo_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        skip_next      = skip_reg;
        start_next     = start_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        total_next     = total_reg;
        quo_next       = quo_reg;
        ovf_next       = ovf_reg;
        zero_next      = zero_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_ACC:
            begin
                if (accept)
                begin
                    acc_next   = acc_new;
                    skip_next  = skip_now;
                    start_next = 1'b0;
                    if (bin.data.last)
                    begin
                        total_next = bin.data.total_size;
                        zero_next  = (bin.data.total_size == '0);
                        num_next   = NUM_W'(prod) << FRACTION_BITS;
                        rem_next   = '0;
                        quo_next   = '0;
                        ovf_next   = 1'b0;
                        step_next  = '0;
                        state_next = (bin.data.total_size == '0) ? ST_DONE : ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                num_next  = num_reg << 1;
                rem_next  = qbit ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
                quo_next  = {quo_reg[SCORE_W-2:0], qbit};
                ovf_next  = ovf_reg | quo_reg[SCORE_W-1];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_data_next.score        = score_val;
                    out_data_next.common_total = acc_reg;
                    out_data_next.zero_total   = zero_reg;
                    out_valid_next             = 1'b1;
                    acc_next                   = '0;
                    skip_next                  = 1'b0;
                    start_next                 = 1'b1;
                    state_next                 = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            acc_reg       <= '0;
            skip_reg      <= 1'b0;
            start_reg     <= 1'b1;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            skip_reg      <= skip_next;
            start_reg     <= start_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        total_reg    <= total_next;
        quo_reg      <= quo_next;
        ovf_reg      <= ovf_next;
        zero_reg     <= zero_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

@@ hdl/lhos_checker.sv @@
// Port-level checks for the label histogram overlap score block, bound to the top level.
// Depends on lhos_pkg and label_histogram_overlap_score_top.
`default_nettype none

module lhos_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         in_last,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [lhos_pkg::SCORE_W-1:0] score,
    input  logic [lhos_pkg::ACC_W-1:0]   common_total,
    input  logic                         zero_total
);
    import lhos_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(score)
            && $stable(common_total) && $stable(zero_total))
        else $error("result beat changed while stalled");

    // stop taking bins while the score is computed
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("bin taken during score computation");

    a_zero_total_score: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_total |-> score == '0)
        else $error("nonzero score with zero total");

    a_no_common_score: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && common_total == '0 |-> score == '0)
        else $error("nonzero score with no common count");

endmodule

bind label_histogram_overlap_score_top lhos_checker u_lhos_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (bin.valid),
    .in_ready     (bin.ready),
    .in_last      (bin.data.last),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .score        (result.data.score),
    .common_total (result.data.common_total),
    .zero_total   (result.data.zero_total)
);

`default_nettype wire

@@ tb/tb_label_histogram_overlap_score_top.sv @@
// Self-checking testbench for label_histogram_overlap_score_top: directed bins, then random runs
// under several valid/ready idling phases, checked beat by beat against an in-bench predictor.
// Depends on lhos_pkg, lhos_in_if, lhos_out_if and the block itself.
`default_nettype none

module tb_label_histogram_overlap_score_top;
    import lhos_pkg::*;

    localparam int SEG_ITEMS   = 150;
    localparam int SEG_COUNT   = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 80;

    typedef struct {
        lhos_in_t  item;
        bit        typed;
        lhos_out_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    lhos_in_if  bin ();
    lhos_out_if result ();

    label_histogram_overlap_score_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bin    (bin),
        .result (result)
    );

    logic [ACC_W-1:0] run_common;
    logic             skip_vertex;
    logic             run_open;

    lhos_out_t pending_results[$];
    dir_row_t  dir_rows[$];
    int        err_count;
    int        idle_pct;
    int        stall_pct;
    bit        hold_req;

    function automatic bit overlap_step(input lhos_in_t b, output lhos_out_t r);
        logic [CNT_W-1:0] m;
        logic [ACC_W:0]   sum;
        logic [63:0]      num;
        logic [63:0]      q;
        r = '0;
        if (run_open)
        begin
            run_common  = b.prior_common;
            skip_vertex = (b.prior_common != '0);
            run_open    = 1'b0;
        end
        m = (b.count_first < b.count_second) ? b.count_first : b.count_second;
        if (!(b.is_vertex_bin && skip_vertex))
        begin
            sum        = {1'b0, run_common} + {{(ACC_W+1-CNT_W){1'b0}}, m};
            run_common = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
        end
        if (!b.last)
            return 1'b0;
        r.common_total = run_common;
        if (b.total_size == '0)
            r.zero_total = 1'b1;
        else
        begin
            num     = (64'(SCALE) * 64'(run_common)) << FRACTION_BITS_DEF;
            q       = num / 64'(b.total_size);
            r.score = (q[63:SCORE_W] != '0) ? {SCORE_W{1'b1}} : q[SCORE_W-1:0];
        end
        run_common  = '0;
        skip_vertex = 1'b0;
        run_open    = 1'b1;
        return 1'b1;
    endfunction

    function automatic lhos_in_t mk_bin(input int a, input int b, input bit v, input int prior,
                                        input int total, input bit lst);
        lhos_in_t it;
        it.count_first   = CNT_W'(a);
        it.count_second  = CNT_W'(b);
        it.is_vertex_bin = v;
        it.prior_common  = ACC_W'(prior);
        it.total_size    = TOTAL_W'(total);
        it.last          = lst;
        return it;
    endfunction

    function automatic void add_row(input lhos_in_t it, input bit typed, input int score,
                                    input int common, input bit zero);
        dir_row_t row;
        row.item              = it;
        row.typed             = typed;
        row.want.score        = SCORE_W'(score);
        row.want.common_total = ACC_W'(common);
        row.want.zero_total   = zero;
        dir_rows = {dir_rows, row};
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return CNT_W'($urandom);
        else if (sel < 70)
            return CNT_W'($urandom_range(255));
        else if (sel < 80)
            return '0;
        else if (sel < 90)
            return {CNT_W{1'b1}};
        return CNT_W'($urandom_range(16));
    endfunction

    task automatic send_bin(input lhos_in_t it, input bit typed, input lhos_out_t want);
        lhos_out_t got;
        while ($urandom_range(99) < idle_pct)
        begin
            bin.valid <= 1'b0;
            @(posedge clk);
        end
        bin.valid <= 1'b1;
        bin.data  <= it;
        @(posedge clk);
        while (!bin.ready)
            @(posedge clk);
        if (overlap_step(it, got))
            pending_results = {pending_results, (typed ? want : got)};
    endtask

    task automatic send_run(output int n);
        lhos_in_t    it;
        lhos_out_t   none;
        int          len;
        int          sel;
        int          est;
        logic [63:0] prior;
        none = '0;
        sel  = $urandom_range(99);
        if (sel < 70)
            len = $urandom_range(1, 6);
        else if (sel < 95)
            len = $urandom_range(7, 20);
        else
            len = $urandom_range(21, 40);
        for (int i = 0; i < len; i++)
        begin
            it.count_first   = rand_count();
            it.count_second  = ($urandom_range(9) == 0) ? it.count_first : rand_count();
            it.is_vertex_bin = $urandom_range(1);
            sel = $urandom_range(99);
            if (i != 0 || sel < 45)
                it.prior_common = (i != 0 && sel < 50) ? ACC_W'($urandom) : '0;
            else if (sel < 75)
                it.prior_common = ACC_W'($urandom);
            else
                it.prior_common = ACC_W'($urandom_range(1, 1000));
            it.last       = (i == len - 1);
            it.total_size = TOTAL_W'($urandom);
            if (it.last)
            begin
                prior = run_open ? 64'(it.prior_common) : 64'(run_common);
                est   = int'(prior) + 1;
                sel   = $urandom_range(99);
                if (sel < 5)
                    it.total_size = '0;
                else if (sel < 40)
                    it.total_size = TOTAL_W'($urandom);
                else if (sel < 60)
                    it.total_size = TOTAL_W'($urandom_range(1, 4000));
                else if (sel < 90)
                    it.total_size = TOTAL_W'(est + $urandom_range(0, est));
                else
                    it.total_size = TOTAL_W'($urandom_range(1, (est > 2) ? est / 2 : 1));
            end
            send_bin(it, 1'b0, none);
        end
        n = len;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("label_histogram_overlap_score_top test failed");
        $finish;
    end

    initial
    begin
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    result.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            result.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        lhos_out_t exp_res;
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result beat score=%0d common=%0d zero=%0d", $time,
                             result.data.score, result.data.common_total, result.data.zero_total);
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (result.data.score !== exp_res.score)
                    begin
                        err_count++;
                        $display("%0t: score expected %0d actual %0d", $time,
                                 exp_res.score, result.data.score);
                    end
                    if (result.data.common_total !== exp_res.common_total)
                    begin
                        err_count++;
                        $display("%0t: common_total expected %0d actual %0d", $time,
                                 exp_res.common_total, result.data.common_total);
                    end
                    if (result.data.zero_total !== exp_res.zero_total)
                    begin
                        err_count++;
                        $display("%0t: zero_total expected %0d actual %0d", $time,
                                 exp_res.zero_total, result.data.zero_total);
                    end
                end
            end
        end
    end

    initial
    begin
        int n;
        int seg_sent;
        err_count   = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 1'b0;
        run_common  = '0;
        skip_vertex = 1'b0;
        run_open    = 1'b1;
        rst_n     <= 1'b0;
        bin.valid <= 1'b0;
        bin.data  <= '0;

        add_row(mk_bin(100, 50, 0, 0, 0, 1), 1, 0, 50, 1);
        add_row(mk_bin(0, 0, 1, 0, 1, 1), 1, 0, 0, 0);
        add_row(mk_bin(100, 100, 0, 0, 100, 1), 1, 51200, 100, 0);
        add_row(mk_bin(1000, 999, 1, 0, 1, 1), 1, 65535, 999, 0);
        add_row(mk_bin(65535, 65535, 0, 0, 2097151, 1), 0, 0, 0, 0);
        add_row(mk_bin(0, 65535, 1, 0, 0, 1), 1, 0, 0, 1);
        add_row(mk_bin(5, 9, 1, 10, 777, 0), 0, 0, 0, 0);
        add_row(mk_bin(20, 30, 1, 55, 12345, 0), 0, 0, 0, 0);
        add_row(mk_bin(3, 4, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(mk_bin(8, 8, 1, 0, 26, 1), 1, 25600, 13, 0);
        add_row(mk_bin(7, 7, 1, 1048575, 0, 0), 0, 0, 0, 0);
        add_row(mk_bin(65535, 65535, 0, 0, 0, 1), 1, 0, 1048575, 1);
        add_row(mk_bin(65535, 1, 0, 1048575, 2097151, 1), 0, 0, 0, 0);
        add_row(mk_bin(40, 60, 1, 0, 2097151, 0), 0, 0, 0, 0);
        add_row(mk_bin(60, 40, 1, 999, 0, 0), 0, 0, 0, 0);
        add_row(mk_bin(65535, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(mk_bin(12, 200, 0, 7, 80, 1), 1, 58880, 92, 0);
        add_row(mk_bin(1, 1, 0, 0, 2097151, 1), 1, 0, 1, 0);
        add_row(mk_bin(65535, 65535, 1, 1, 1, 1), 1, 51200, 1, 0);
        add_row(mk_bin(0, 0, 0, 0, 2097151, 0), 0, 0, 0, 0);
        add_row(mk_bin(0, 0, 0, 0, 0, 1), 1, 0, 0, 1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_bin(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            if (seg == 4)
                hold_req = 1'b1;
            seg_sent = 0;
            while (seg_sent < SEG_ITEMS)
            begin
                send_run(n);
                seg_sent += n;
            end
        end

        bin.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0)
            $display("label_histogram_overlap_score_top test passed");
        else
            $display("label_histogram_overlap_score_top test failed");
        $finish;
    end
endmodule

`default_nettype wire

@@ sim.f @@
hdl/lhos_pkg.sv
hdl/lhos_in_if.sv
hdl/lhos_out_if.sv
hdl/label_histogram_overlap_score_top.sv
hdl/lhos_checker.sv
tb/tb_label_histogram_overlap_score_top.sv
